// File: sv/efd_pkg.sv
// shared constants, status codes and request types for the escaped frame deframer
// no dependencies

package efd_pkg;

    localparam int PAYLOAD_BYTES_DEF = 9;

    localparam logic [7:0] DELIM   = 8'h7E;
    localparam logic [7:0] ESC     = 8'h7D;
    localparam logic [7:0] ESC_XOR = 8'h20;

    typedef enum logic [1:0] {
        ST_PAYLOAD     = 2'd0,
        ST_BAD_START   = 2'd1,
        ST_BAD_END     = 2'd2,
        ST_EXTRA_DELIM = 2'd3
    } status_t;

    // request from the parser to the burst reader
    typedef struct packed {
        logic    start;
        logic    bank;
        logic    err;
        status_t status;
    } efd_req_t;

    // bits needed for a payload index
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // bits needed for the frame position, 0 .. n+1
    function automatic int pos_width(input int n);
        return $clog2(n + 2);
    endfunction

endpackage

// File: sv/efd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module efd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: sv/efd_parser.sv
// byte parser: sync hunt, delimiter checks, unescaping and frame store writes
// depends on efd_pkg

module efd_parser #(
    parameter int PAYLOAD_BYTES = efd_pkg::PAYLOAD_BYTES_DEF,
    parameter int AW = efd_pkg::idx_width(PAYLOAD_BYTES) + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             out_free,
    output efd_pkg::efd_req_t req,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [7:0]       wr_data
);

    import efd_pkg::*;

    localparam int IDX_W = idx_width(PAYLOAD_BYTES);
    localparam int POS_W = pos_width(PAYLOAD_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             synced_reg, synced_next;
    logic             esc_reg, esc_next;
    logic             second_reg, second_next;
    logic             bank_reg;

    logic             is_err, is_end, do_write, accept;
    status_t          err_status;
    logic [7:0]       data_c;
    logic [IDX_W-1:0] slot;

    // decode of one byte against the current frame position
    always_comb
    begin
        pos_next    = pos_reg;
        synced_next = synced_reg;
        esc_next    = esc_reg;
        second_next = second_reg;
        is_err      = 1'b0;
        is_end      = 1'b0;
        err_status  = ST_PAYLOAD;
        do_write    = 1'b0;
        data_c      = in_byte;
        if (!synced_reg)
        begin
            if (pos_reg == '0)
            begin
                if (in_byte == DELIM)
                begin
                    pos_next = POS_W'(1);
                end
            end
            else if (pos_reg != POS_W'(1))
            begin
                pos_next    = '0;
                esc_next    = 1'b0;
                second_next = 1'b0;
            end
            else if (in_byte == DELIM)
            begin
                if (second_reg)
                begin
                    is_err     = 1'b1;
                    err_status = ST_EXTRA_DELIM;
                end
                else
                begin
                    second_next = 1'b1;
                end
            end
            else
            begin
                // first payload byte gains sync
                synced_next = 1'b1;
                second_next = 1'b0;
                if (in_byte == ESC)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next = 1'b0;
                    do_write = 1'b1;
                    pos_next = POS_W'(2);
                end
            end
        end
        else if (pos_reg == '0)
        begin
            if (in_byte == DELIM)
            begin
                pos_next = POS_W'(1);
            end
            else
            begin
                is_err     = 1'b1;
                err_status = ST_BAD_START;
            end
        end
        else if (pos_reg <= POS_W'(PAYLOAD_BYTES))
        begin
            if (esc_reg)
            begin
                data_c   = in_byte ^ ESC_XOR;
                esc_next = 1'b0;
                do_write = 1'b1;
                pos_next = pos_reg + POS_W'(1);
            end
            else if (in_byte == ESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                do_write = 1'b1;
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else if (pos_reg == POS_W'(PAYLOAD_BYTES + 1))
        begin
            if (in_byte == DELIM)
            begin
                is_end   = 1'b1;
                pos_next = '0;
                esc_next = 1'b0;
            end
            else
            begin
                is_err     = 1'b1;
                err_status = ST_BAD_END;
            end
        end
        else
        begin
            // stray position: back to hunting
            synced_next = 1'b0;
            pos_next    = '0;
            esc_next    = 1'b0;
            second_next = 1'b0;
        end
        if (is_err)
        begin
            synced_next = 1'b0;
            pos_next    = '0;
            esc_next    = 1'b0;
            second_next = 1'b0;
        end
    end

    // hold off a result-causing byte while the output side is busy
    assign in_stall = in_valid && (is_err || is_end) && !out_free;
    assign accept   = in_valid && !in_stall;

    assign slot    = IDX_W'(pos_reg - POS_W'(1));
    assign wr_en   = accept && do_write;
    assign wr_addr = {bank_reg, slot};
    assign wr_data = data_c;

    assign req.start  = accept && is_end;
    assign req.bank   = bank_reg;
    assign req.err    = accept && is_err;
    assign req.status = err_status;

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            synced_reg <= 1'b0;
            esc_reg    <= 1'b0;
            second_reg <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            synced_reg <= synced_next;
            esc_reg    <= esc_next;
            second_reg <= second_next;
            if (is_end)
            begin
                bank_reg <= !bank_reg;
            end
        end
    end

endmodule

// File: sv/efd_burst.sv
// burst reader: reads a finished frame out of the ram and queues results
// depends on efd_pkg

module efd_burst #(
    parameter int PAYLOAD_BYTES = efd_pkg::PAYLOAD_BYTES_DEF,
    parameter int IDX_W = efd_pkg::idx_width(PAYLOAD_BYTES),
    parameter int AW = IDX_W + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  efd_pkg::efd_req_t req,
    output logic              out_free,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [7:0]        rd_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        payload_byte,
    output logic [IDX_W-1:0]  byte_index,
    output logic [1:0]        status,
    output logic              last
);

    import efd_pkg::*;

    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        status_t          st;
        logic             lst;
    } entry_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    logic             busy_reg;
    logic             bank_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             infl_reg;
    logic [IDX_W-1:0] infl_idx_reg;
    entry_t           fifo_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;

    logic       pop, push, issue;
    logic [1:0] cnt_after, occupancy;
    entry_t     push_entry;
    entry_t     head;

    // occupancy once this cycle's pop and the read in flight are counted
    assign pop       = out_valid && !out_stall;
    assign cnt_after = cnt_reg - {1'b0, pop};
    assign occupancy = cnt_after + {1'b0, infl_reg};
    assign issue     = busy_reg && (occupancy < 2'd2);
    assign out_free  = !busy_reg && !infl_reg && (cnt_after < 2'd2);

    assign rd_en   = issue;
    assign rd_addr = {bank_reg, rd_idx_reg};

    // queue entry from ram data or from an error request
    always_comb
    begin
        if (infl_reg)
        begin
            push_entry.data = rd_data;
            push_entry.idx  = infl_idx_reg;
            push_entry.st   = ST_PAYLOAD;
            push_entry.lst  = (infl_idx_reg == LAST_IDX);
        end
        else
        begin
            push_entry.data = '0;
            push_entry.idx  = '0;
            push_entry.st   = req.status;
            push_entry.lst  = 1'b1;
        end
    end
    assign push = infl_reg || req.err;

    // read sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            bank_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            infl_reg     <= 1'b0;
            infl_idx_reg <= '0;
        end
        else
        begin
            infl_reg <= issue;
            if (issue)
            begin
                infl_idx_reg <= rd_idx_reg;
                if (rd_idx_reg == LAST_IDX)
                begin
                    busy_reg   <= 1'b0;
                    rd_idx_reg <= '0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
            end
            else if (req.start)
            begin
                busy_reg   <= 1'b1;
                bank_reg   <= req.bank;
                rd_idx_reg <= '0;
            end
        end
    end

    // two-entry result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_after + {1'b0, push};
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign out_valid    = (cnt_reg != 2'd0);
    assign payload_byte = head.data;
    assign byte_index   = head.idx;
    assign status       = head.st;
    assign last         = head.lst;

endmodule

// File: sv/escaped_fixed_frame_deframer_unit.sv
// top level of the escaped fixed-length frame deframer
// depends on efd_pkg, efd_ram, efd_parser, efd_burst

// One raw byte is taken per cycle while in_stall is low. A frame is a 0x7E start,
// PAYLOAD_BYTES payload bytes (0x7D escapes the next byte, which is XORed with
// 0x20) and a 0x7E end; the end delimiter releases the payload as a run of
// PAYLOAD_BYTES results, one per cycle while out_stall is low, read from a
// two-bank frame ram through its single read port, the final one with last set.
// Error results (bad start, bad end, extra delimiter while resyncing) are single
// results with last set and zero data and index. Bytes that cause a result are
// held with in_stall while the previous run is still being read out, while its
// last ram read is in flight or while the two-entry output queue is full. All
// other bytes go straight in. No clearing pass is needed after reset.

module escaped_fixed_frame_deframer_unit #(
    parameter int PAYLOAD_BYTES = efd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [7:0]                                in_byte,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [7:0]                                payload_byte,
    output logic [efd_pkg::idx_width(PAYLOAD_BYTES)-1:0] byte_index,
    output logic [1:0]                                status,
    output logic                                      last
);

    import efd_pkg::*;

    localparam int IDX_W = idx_width(PAYLOAD_BYTES);
    localparam int AW    = IDX_W + 1;
    localparam int DEPTH = 2 ** AW;

    efd_req_t        req;
    logic            out_free;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [7:0]      wr_data, rd_data;

    // two frame banks, one filling while the other is read out
    efd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // input side
    efd_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .AW            (AW)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .out_free (out_free),
        .req      (req),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // output side
    efd_burst #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W),
        .AW            (AW)
    ) u_burst (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .out_free     (out_free),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .status       (status),
        .last         (last)
    );

endmodule

// File: sv/efd_checker.sv
// port-level checks for the escaped frame deframer, bound to the top level
// depends on efd_pkg and escaped_fixed_frame_deframer_unit

module efd_checker #(
    parameter int PAYLOAD_BYTES = efd_pkg::PAYLOAD_BYTES_DEF
) (
    input logic                                         clk,
    input logic                                         rst_n,
    input logic                                         out_valid,
    input logic                                         out_stall,
    input logic [7:0]                                   payload_byte,
    input logic [efd_pkg::idx_width(PAYLOAD_BYTES)-1:0] byte_index,
    input logic [1:0]                                   status,
    input logic                                         last
);

    import efd_pkg::*;

    localparam int IDX_W = idx_width(PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    // error results are single, zeroed and marked last
    property p_err_shape;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_PAYLOAD)
            |-> (last && byte_index == '0 && payload_byte == 8'd0);
    endproperty
    a_err_shape : assert property (p_err_shape)
        else $error("error result not zeroed or not last");

    // a payload result is last exactly at the final index
    property p_last_idx;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_PAYLOAD) |-> (last == (byte_index == LAST_IDX));
    endproperty
    a_last_idx : assert property (p_last_idx)
        else $error("last flag does not match final payload index");

    // a run continues with the next index and no interleaved error
    property p_run_order;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status == ST_PAYLOAD && !last)
            |=> (!out_valid || (status == ST_PAYLOAD
                 && byte_index == IDX_W'($past(byte_index) + 1'b1)));
    endproperty
    a_run_order : assert property (p_run_order)
        else $error("payload run out of order");

    // a stalled result is held
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
            |=> (out_valid && $stable(payload_byte) && $stable(byte_index)
                 && $stable(status) && $stable(last));
    endproperty
    a_hold : assert property (p_hold)
        else $error("stalled result changed");

endmodule

bind escaped_fixed_frame_deframer_unit efd_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_efd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .status       (status),
    .last         (last)
);

// File: test/efd_frame_checker.sv
// checker for the escaped frame deframer: predicts results from accepted bytes and compares
// depends on efd_pkg

`timescale 1ns / 100ps

module efd_frame_checker #(
    parameter int PAYLOAD_BYTES = efd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic                                         in_stall,
    input  logic [7:0]                                   in_byte,
    input  logic                                         out_valid,
    input  logic                                         out_stall,
    input  logic [7:0]                                   payload_byte,
    input  logic [efd_pkg::idx_width(PAYLOAD_BYTES)-1:0] byte_index,
    input  logic [1:0]                                   status,
    input  logic                                         last,
    output int                                           fail_count,
    output int                                           pending_count
);

    import efd_pkg::*;

    localparam int IW = idx_width(PAYLOAD_BYTES);
    localparam int PW = pos_width(PAYLOAD_BYTES);

    typedef struct packed {
        logic [7:0]    data;
        logic [IW-1:0] index;
        status_t       st;
        logic          last;
    } frame_result_t;

    // predicted deframer state
    logic [7:0]    frame_bytes [PAYLOAD_BYTES];
    logic [PW-1:0] frame_pos;
    bit            in_sync;
    bit            esc_pending;
    bit            second_delim;

    frame_result_t expected_results [$];

    // drop sync and queue a single error result
    task automatic flag_error(input status_t st);
        frame_result_t r;
        in_sync      = 1'b0;
        frame_pos    = '0;
        esc_pending  = 1'b0;
        second_delim = 1'b0;
        r.data  = '0;
        r.index = '0;
        r.st    = st;
        r.last  = 1'b1;
        expected_results.push_back(r);
    endtask

    // store one payload byte, undoing the escape
    task automatic store_payload(input logic [7:0] b);
        if (frame_pos < 1 || frame_pos > PAYLOAD_BYTES) begin
            frame_pos   = '0;
            in_sync     = 1'b0;
            esc_pending = 1'b0;
        end
        else if (esc_pending) begin
            frame_bytes[IW'(frame_pos - 1'b1)] = b ^ ESC_XOR;
            esc_pending = 1'b0;
            frame_pos   = frame_pos + 1'b1;
        end
        else if (b == ESC) begin
            esc_pending = 1'b1;
        end
        else begin
            frame_bytes[IW'(frame_pos - 1'b1)] = b;
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    // advance the predicted deframer by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        frame_result_t r;
        if (!in_sync) begin
            if (frame_pos == 0) begin
                if (b == DELIM)
                    frame_pos = 1;
            end
            else if (frame_pos != 1) begin
                frame_pos    = '0;
                esc_pending  = 1'b0;
                second_delim = 1'b0;
            end
            else if (b == DELIM) begin
                if (second_delim)
                    flag_error(ST_EXTRA_DELIM);
                else
                    second_delim = 1'b1;
            end
            else begin
                in_sync      = 1'b1;
                second_delim = 1'b0;
                esc_pending  = 1'b0;
                store_payload(b);
            end
        end
        else if (frame_pos == 0) begin
            if (b == DELIM)
                frame_pos = 1;
            else
                flag_error(ST_BAD_START);
        end
        else if (frame_pos <= PAYLOAD_BYTES) begin
            store_payload(b);
        end
        else if (frame_pos == PAYLOAD_BYTES + 1) begin
            if (b != DELIM) begin
                flag_error(ST_BAD_END);
            end
            else begin
                frame_pos   = '0;
                esc_pending = 1'b0;
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    r.data  = frame_bytes[i[IW-1:0]];
                    r.index = i[IW-1:0];
                    r.st    = ST_PAYLOAD;
                    r.last  = (i == PAYLOAD_BYTES - 1);
                    expected_results.push_back(r);
                end
            end
        end
        else begin
            in_sync      = 1'b0;
            frame_pos    = '0;
            esc_pending  = 1'b0;
            second_delim = 1'b0;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t exp_r;
        if (!rst_n) begin
            frame_pos    = '0;
            in_sync      = 1'b0;
            esc_pending  = 1'b0;
            second_delim = 1'b0;
            expected_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else begin
            if (in_valid && !in_stall)
                deframe_byte(in_byte);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: payload_byte %0h byte_index %0d %s",
                           payload_byte, byte_index,
                           $sformatf("status %0d last %0b", status, last));
                    fail_count++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (payload_byte !== exp_r.data) begin
                        $error("payload_byte: expected %0h, actual %0h",
                               exp_r.data, payload_byte);
                        fail_count++;
                    end
                    if (byte_index !== exp_r.index) begin
                        $error("byte_index: expected %0d, actual %0d",
                               exp_r.index, byte_index);
                        fail_count++;
                    end
                    if (status !== exp_r.st) begin
                        $error("status: expected %0d, actual %0d", exp_r.st, status);
                        fail_count++;
                    end
                    if (last !== exp_r.last) begin
                        $error("last: expected %0b, actual %0b", exp_r.last, last);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// File: test/escaped_fixed_frame_deframer_unit_tb.sv
// testbench top for the escaped frame deframer: clock, reset, byte stimulus and verdict
// depends on efd_pkg, escaped_fixed_frame_deframer_unit and efd_frame_checker

`timescale 1ns / 100ps

module escaped_fixed_frame_deframer_unit_tb;

    import efd_pkg::*;

    localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
    localparam int IW = idx_width(PAYLOAD_BYTES);

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [7:0]    in_byte;
    logic          out_valid;
    logic          out_stall;
    logic [7:0]    payload_byte;
    logic [IW-1:0] byte_index;
    logic [1:0]    status;
    logic          last;
    int            fail_count;
    int            pending_count;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int bytes_sent;

    escaped_fixed_frame_deframer_unit #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .status       (status),
        .last         (last)
    );

    efd_frame_checker #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .status        (status),
        .last          (last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // overall time limit
    initial
    begin
        #1ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else begin
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    // offer one byte, with a random gap first, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_non_delim();
        logic [7:0] v;
        v = 8'($urandom_range(255, 0));
        if (v == DELIM)
            v = ~v;
        return v;
    endfunction

    // payload of random bytes, leaning on the delimiter and escape codes
    task automatic send_payload();
        logic [7:0] value;
        int         pick;
        for (int k = 0; k < PAYLOAD_BYTES; k++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 10)
                value = DELIM;
            else if (pick < 20)
                value = ESC;
            else if (pick < 25)
                value = DELIM ^ ESC_XOR;
            else if (pick < 30)
                value = ESC ^ ESC_XOR;
            else
                value = 8'($urandom_range(255, 0));
            // escape code always escaped; a delimiter mostly escaped, else left bare
            if (value == ESC || (value == DELIM && $urandom_range(99, 0) < 70)
                    || $urandom_range(99, 0) < 10) begin
                send_byte(ESC);
                send_byte(value ^ ESC_XOR);
            end
            else begin
                send_byte(value);
            end
        end
    endtask

    // one frame, with a good or a broken end delimiter
    task automatic send_frame(input bit good_end);
        if ($urandom_range(99, 0) < 15)
            send_byte(DELIM);
        send_byte(DELIM);
        send_payload();
        if (good_end)
            send_byte(DELIM);
        else
            send_byte(rand_non_delim());
    endtask

    // mostly good frames, the rest broken frames, noise and delimiter runs
    task automatic run_random(input int n_items);
        int start_count;
        int pick;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_items)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 72)
                send_frame(1'b1);
            else if (pick < 82)
                send_frame(1'b0);
            else if (pick < 89)
                repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255, 0)));
            else if (pick < 95)
                repeat (3) send_byte(DELIM);
            else
                send_byte(rand_non_delim());
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = '0;
        hold_left     = 0;
        bytes_sent    = 0;
        send_idle_pct = 7;
        recv_idle_pct = 68;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // noise while hunting, then a third delimiter
        send_byte(8'h00);
        send_byte(DELIM);
        send_byte(DELIM);
        send_byte(DELIM);
        // good frame: extremes, escaped delimiter and escape, bare delimiter as data
        send_byte(DELIM);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ESC);
        send_byte(DELIM ^ ESC_XOR);
        send_byte(ESC);
        send_byte(ESC ^ ESC_XOR);
        send_byte(DELIM);
        send_byte(ESC);
        send_byte(DELIM);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(DELIM);
        // bad start once synced
        send_byte(8'hFF);

        run_random(160);

        send_idle_pct = 68;
        recv_idle_pct = 7;
        run_random(160);

        // no idling, with a long receiver hold-off to fill the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 150;
        run_random(160);

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (4 * PAYLOAD_BYTES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
